// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
// each macro expects a clock named clk and an active-low reset named rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg
// shared widths, function codes and internal bundles of the integer alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ialu_pkg;

  localparam int WORD_W  = 32;
  localparam int FUNC_W  = 5;
  localparam int SHAMT_W = 5;
  localparam int CLZ_W   = 6;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_NOR    = 5'd0,
    FUNC_AND    = 5'd1,
    FUNC_OR     = 5'd2,
    FUNC_XOR    = 5'd3,
    FUNC_EQ     = 5'd4,
    FUNC_NE     = 5'd5,
    FUNC_LT     = 5'd6,
    FUNC_LTU    = 5'd7,
    FUNC_GTE    = 5'd8,
    FUNC_GTEU   = 5'd9,
    FUNC_SLL    = 5'd10,
    FUNC_SRL    = 5'd11,
    FUNC_SRA    = 5'd12,
    FUNC_ADD    = 5'd13,
    FUNC_SUB    = 5'd14,
    FUNC_PSEL   = 5'd15,
    FUNC_MULHW  = 5'd16,
    FUNC_MULLW  = 5'd17,
    FUNC_MULHWU = 5'd18,
    FUNC_CLZ    = 5'd19
  } func_t;

  // multiplier outputs
  typedef struct packed {
    logic [WORD_W-1:0] hi_s;
    logic [WORD_W-1:0] hi_u;
    logic [WORD_W-1:0] lo;
  } mul_res_t;

  // execute outputs
  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              invalid;
  } exec_res_t;

endpackage

// ===== hw/rtl/ialu_mul.sv =====
// ----------------------------------------------------------------------------
// ialu_mul
// 32x32 unsigned product with signed high word correction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ialu_mul (
  input  logic [ialu_pkg::WORD_W-1:0] a,
  input  logic [ialu_pkg::WORD_W-1:0] b,
  output ialu_pkg::mul_res_t          res
);

  localparam int W = ialu_pkg::WORD_W;

  logic [2*W-1:0] prod;
  logic [W-1:0]   corr_a;
  logic [W-1:0]   corr_b;

  // full unsigned product
  assign prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};

  // a negative operand adds minus the other operand to the high word
  assign corr_a = a[W-1] ? b : '0;
  assign corr_b = b[W-1] ? a : '0;

  assign res.lo   = prod[W-1:0];
  assign res.hi_u = prod[2*W-1:W];
  assign res.hi_s = prod[2*W-1:W] - corr_a - corr_b;

endmodule

// ===== hw/rtl/ialu_clz.sv =====
// ----------------------------------------------------------------------------
// ialu_clz
// leading zero count, nibble counts merged by a short priority pick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ialu_clz (
  input  logic [ialu_pkg::WORD_W-1:0] a,
  output logic [ialu_pkg::CLZ_W-1:0]  count
);

  localparam int W      = ialu_pkg::WORD_W;
  localparam int NIB    = W / 4;
  localparam int NIDX_W = $clog2(NIB);

  // leading zeros of one nonzero-or-zero nibble (zero nibble is not used)
  function automatic logic [1:0] nib_clz(input logic [3:0] n);
    logic [1:0] c;
    if (n[3])      c = 2'd0;
    else if (n[2]) c = 2'd1;
    else if (n[1]) c = 2'd2;
    else           c = 2'd3;
    return c;
  endfunction

  logic [NIB-1:0] nz;
  logic [1:0]     nclz [NIB];

  // per-nibble counts, nibble 0 is the most significant
  always_comb begin
    for (int i = 0; i < NIB; i++) begin
      nz[i]   = |a[W-1-4*i -: 4];
      nclz[i] = nib_clz(a[W-1-4*i -: 4]);
    end
  end

  // first nonzero nibble from the top
  always_comb begin
    logic              found;
    logic [NIDX_W-1:0] idx;
    logic [1:0]        low;
    found = 1'b0;
    idx   = '0;
    low   = '0;
    for (int i = 0; i < NIB; i++) begin
      if (!found && nz[i]) begin
        found = 1'b1;
        idx   = NIDX_W'(i);
        low   = nclz[i];
      end
    end
    if (found) count = {1'b0, idx, low};
    else       count = ialu_pkg::CLZ_W'(W);
  end

endmodule

// ===== hw/rtl/ialu_exec.sv =====
// ----------------------------------------------------------------------------
// ialu_exec
// function decode and result selection for one operation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ialu_exec (
  input  logic [ialu_pkg::FUNC_W-1:0] func,
  input  logic [ialu_pkg::WORD_W-1:0] a,
  input  logic [ialu_pkg::WORD_W-1:0] b,
  input  logic                        pred,
  output ialu_pkg::exec_res_t         res
);

  localparam int W = ialu_pkg::WORD_W;

  ialu_pkg::mul_res_t            mul;
  logic [ialu_pkg::CLZ_W-1:0]    clz;
  logic [ialu_pkg::SHAMT_W-1:0]  sh;
  logic                          lt_s;
  logic                          lt_u;

  ialu_mul u_mul (
    .a   (a),
    .b   (b),
    .res (mul)
  );

  ialu_clz u_clz (
    .a     (a),
    .count (clz)
  );

  assign sh   = b[ialu_pkg::SHAMT_W-1:0];
  assign lt_s = $signed(a) < $signed(b);
  assign lt_u = a < b;

  // result select, unknown codes flag an error and give zero
  always_comb begin
    res.result  = '0;
    res.invalid = 1'b0;
    case (ialu_pkg::func_t'(func))
      ialu_pkg::FUNC_NOR:    res.result = ~(a | b);
      ialu_pkg::FUNC_AND:    res.result = a & b;
      ialu_pkg::FUNC_OR:     res.result = a | b;
      ialu_pkg::FUNC_XOR:    res.result = a ^ b;
      ialu_pkg::FUNC_EQ:     res.result = {{(W-1){1'b0}}, a == b};
      ialu_pkg::FUNC_NE:     res.result = {{(W-1){1'b0}}, a != b};
      ialu_pkg::FUNC_LT:     res.result = {{(W-1){1'b0}}, lt_s};
      ialu_pkg::FUNC_LTU:    res.result = {{(W-1){1'b0}}, lt_u};
      ialu_pkg::FUNC_GTE:    res.result = {{(W-1){1'b0}}, !lt_s};
      ialu_pkg::FUNC_GTEU:   res.result = {{(W-1){1'b0}}, !lt_u};
      ialu_pkg::FUNC_SLL:    res.result = a << sh;
      ialu_pkg::FUNC_SRL:    res.result = a >> sh;
      ialu_pkg::FUNC_SRA:    res.result = $unsigned($signed(a) >>> sh);
      ialu_pkg::FUNC_ADD:    res.result = a + b;
      ialu_pkg::FUNC_SUB:    res.result = a - b;
      ialu_pkg::FUNC_PSEL:   res.result = pred ? a : b;
      ialu_pkg::FUNC_MULHW:  res.result = mul.hi_s;
      ialu_pkg::FUNC_MULLW:  res.result = mul.lo;
      ialu_pkg::FUNC_MULHWU: res.result = mul.hi_u;
      ialu_pkg::FUNC_CLZ:    res.result = {{(W-ialu_pkg::CLZ_W){1'b0}}, clz};
      default: begin
        res.result  = '0;
        res.invalid = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/integer_alu_32bit.sv =====
// timing: an accepted transaction passes through the operand register and then the
// result register, and out_valid is the registered valid of the result register
// throughput: one transaction per cycle, set by the single execute stage
// between the operand register and the result register; busy stays low
// reset: synchronous active-low rst_n clears the valid flags only
// ----------------------------------------------------------------------------
// integer_alu_32bit
// 32-bit integer alu: logic, compare, shift, add, select, multiply and clz
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module integer_alu_32bit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic        [ialu_pkg::FUNC_W-1:0] in_func,
  input  logic signed [ialu_pkg::WORD_W-1:0] in_operand_a,
  input  logic signed [ialu_pkg::WORD_W-1:0] in_operand_b,
  input  logic                               in_predicate,
  output logic                               out_valid,
  output logic signed [ialu_pkg::WORD_W-1:0] out_result,
  output logic                               out_invalid_function
);

  logic                          s1_valid_r;
  logic [ialu_pkg::FUNC_W-1:0]   s1_func_r;
  logic [ialu_pkg::WORD_W-1:0]   s1_a_r;
  logic [ialu_pkg::WORD_W-1:0]   s1_b_r;
  logic                          s1_pred_r;
  logic                          out_valid_r;
  ialu_pkg::exec_res_t           out_res_r;
  ialu_pkg::exec_res_t           exec_nxt;
  logic                          accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // operand register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_func_r <= in_func;
      s1_a_r    <= $unsigned(in_operand_a);
      s1_b_r    <= $unsigned(in_operand_b);
      s1_pred_r <= in_predicate;
    end
  end

  ialu_exec u_exec (
    .func (s1_func_r),
    .a    (s1_a_r),
    .b    (s1_b_r),
    .pred (s1_pred_r),
    .res  (exec_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_valid_r) begin
      out_res_r <= exec_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result           = $signed(out_res_r.result);
  assign out_invalid_function = out_res_r.invalid;

  // checks
  `ASSERT_NEXT(a_accept_loads, accept, s1_valid_r)
  `ASSERT_NEXT(a_stage_to_out, s1_valid_r, out_valid)
  `ASSERT_SAME(a_invalid_zero, out_valid && out_invalid_function, out_result == '0)

endmodule

// ===== bench/integer_alu_32bit_tb.sv =====
// ----------------------------------------------------------------------------
// integer_alu_32bit_tb
// self-checking bench for the 32-bit integer alu: a directed pass over every
// defined function code and its corner operands, then random transactions
// in phases with different amounts of sender idling; results are checked in
// order against a behavioral model of the alu kept in a small scoreboard class
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_alu_32bit_tb;

  // function codes with no defined operation
  localparam logic [ialu_pkg::FUNC_W-1:0] FUNC_FIRST_UNDEF = 5'd20;
  localparam logic [ialu_pkg::FUNC_W-1:0] FUNC_LAST_UNDEF  = 5'd31;

  localparam int RANDOM_PER_PHASE = 180;
  localparam int DRAIN_LIMIT      = 100;
  localparam int SETTLE_CYCLES    = 4;

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  logic        [ialu_pkg::FUNC_W-1:0] in_func;
  logic signed [ialu_pkg::WORD_W-1:0] in_operand_a;
  logic signed [ialu_pkg::WORD_W-1:0] in_operand_b;
  logic                               in_predicate;
  logic                               out_valid;
  logic signed [ialu_pkg::WORD_W-1:0] out_result;
  logic                               out_invalid_function;

  // expected alu words, oldest first
  class alu_scoreboard;
    ialu_pkg::exec_res_t results_due[$];
    int unsigned         fail_cnt;

    function new();
      fail_cnt = 0;
    endfunction

    // behavioral model of one alu operation
    function automatic ialu_pkg::exec_res_t alu_expect(
        input logic [ialu_pkg::FUNC_W-1:0] fn,
        input logic [ialu_pkg::WORD_W-1:0] a,
        input logic [ialu_pkg::WORD_W-1:0] b,
        input logic                        pred);
      logic [2*ialu_pkg::WORD_W-1:0] prod_u;
      logic [2*ialu_pkg::WORD_W-1:0] prod_s;
      logic [ialu_pkg::SHAMT_W-1:0]  sh;
      int                            zeros;
      ialu_pkg::exec_res_t           r;
      prod_u    = {{ialu_pkg::WORD_W{1'b0}}, a} * {{ialu_pkg::WORD_W{1'b0}}, b};
      prod_s    = {{ialu_pkg::WORD_W{a[ialu_pkg::WORD_W-1]}}, a} *
                  {{ialu_pkg::WORD_W{b[ialu_pkg::WORD_W-1]}}, b};
      sh        = b[ialu_pkg::SHAMT_W-1:0];
      r.result  = '0;
      r.invalid = 1'b0;
      case (fn)
        ialu_pkg::FUNC_NOR:    r.result = ~(a | b);
        ialu_pkg::FUNC_AND:    r.result = a & b;
        ialu_pkg::FUNC_OR:     r.result = a | b;
        ialu_pkg::FUNC_XOR:    r.result = a ^ b;
        ialu_pkg::FUNC_EQ:     r.result = (a == b) ? 1 : 0;
        ialu_pkg::FUNC_NE:     r.result = (a != b) ? 1 : 0;
        ialu_pkg::FUNC_LT:     r.result = ($signed(a) < $signed(b)) ? 1 : 0;
        ialu_pkg::FUNC_LTU:    r.result = (a < b) ? 1 : 0;
        ialu_pkg::FUNC_GTE:    r.result = ($signed(a) >= $signed(b)) ? 1 : 0;
        ialu_pkg::FUNC_GTEU:   r.result = (a >= b) ? 1 : 0;
        ialu_pkg::FUNC_SLL:    r.result = a << sh;
        ialu_pkg::FUNC_SRL:    r.result = a >> sh;
        ialu_pkg::FUNC_SRA:    r.result = $signed(a) >>> sh;
        ialu_pkg::FUNC_ADD:    r.result = a + b;
        ialu_pkg::FUNC_SUB:    r.result = a - b;
        ialu_pkg::FUNC_PSEL:   r.result = pred ? a : b;
        ialu_pkg::FUNC_MULHW:  r.result = prod_s[2*ialu_pkg::WORD_W-1:ialu_pkg::WORD_W];
        ialu_pkg::FUNC_MULLW:  r.result = prod_u[ialu_pkg::WORD_W-1:0];
        ialu_pkg::FUNC_MULHWU: r.result = prod_u[2*ialu_pkg::WORD_W-1:ialu_pkg::WORD_W];
        ialu_pkg::FUNC_CLZ: begin
          // highest set bit wins, no set bit leaves the full width
          zeros = ialu_pkg::WORD_W;
          for (int i = 0; i < ialu_pkg::WORD_W; i++) begin
            if (a[i]) zeros = ialu_pkg::WORD_W - 1 - i;
          end
          r.result = zeros;
        end
        default: begin
          r.invalid = 1'b1;
        end
      endcase
      return r;
    endfunction

    function void note_op(input logic [ialu_pkg::FUNC_W-1:0] fn,
                          input logic [ialu_pkg::WORD_W-1:0] a,
                          input logic [ialu_pkg::WORD_W-1:0] b,
                          input logic                        pred);
      results_due.push_back(alu_expect(fn, a, b, pred));
    endfunction

    function void check_result(input logic [ialu_pkg::WORD_W-1:0] word, input logic bad);
      ialu_pkg::exec_res_t exp_r;
      if (results_due.size() == 0) begin
        $error("result %h (invalid_function %b) with no transaction pending", word, bad);
        fail_cnt++;
        return;
      end
      exp_r = results_due.pop_front();
      if (word !== exp_r.result) begin
        $error("result: expected %h, got %h", exp_r.result, word);
        fail_cnt++;
      end
      if (bad !== exp_r.invalid) begin
        $error("invalid_function: expected %b, got %b", exp_r.invalid, bad);
        fail_cnt++;
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  alu_scoreboard sb;

  integer_alu_32bit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_func              (in_func),
    .in_operand_a         (in_operand_a),
    .in_operand_b         (in_operand_b),
    .in_predicate         (in_predicate),
    .out_valid            (out_valid),
    .out_result           (out_result),
    .out_invalid_function (out_invalid_function)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_result, out_invalid_function);
    end
  end

  // one transaction, held until accepted
  task automatic send_op(input logic [ialu_pkg::FUNC_W-1:0] fn,
                         input logic [ialu_pkg::WORD_W-1:0] a,
                         input logic [ialu_pkg::WORD_W-1:0] b,
                         input logic                        pred);
    @(negedge clk);
    start        <= 1'b1;
    in_func      <= fn;
    in_operand_a <= a;
    in_operand_b <= b;
    in_predicate <= pred;
    do @(posedge clk); while (busy);
    sb.note_op(fn, a, b, pred);
  endtask

  // sender idle, with junk on the payload
  task automatic idle_gap(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start        <= 1'b0;
      in_func      <= ialu_pkg::FUNC_W'($urandom);
      in_operand_a <= $urandom;
      in_operand_b <= $urandom;
      in_predicate <= 1'($urandom);
    end
  endtask

  // hold off until every pending result is back, then let the pipe settle
  task automatic wait_results_done();
    int n;
    n = 0;
    idle_gap(1);
    while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.fail_cnt++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // operand mix: extremes, small values, partial masks, full random
  function automatic logic [ialu_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(64, 0);
      5:       return $urandom >> $urandom_range(31, 0);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_op();
    logic [ialu_pkg::FUNC_W-1:0] fn;
    logic [ialu_pkg::WORD_W-1:0] a;
    logic [ialu_pkg::WORD_W-1:0] b;
    if ($urandom_range(99, 0) < 10) begin
      fn = ialu_pkg::FUNC_W'($urandom_range(FUNC_LAST_UNDEF, FUNC_FIRST_UNDEF));
    end else begin
      fn = ialu_pkg::FUNC_W'($urandom_range(ialu_pkg::FUNC_CLZ, ialu_pkg::FUNC_NOR));
    end
    a = pick_word();
    // equal operands now and then for the compares
    b = ($urandom_range(3, 0) == 0) ? a : pick_word();
    send_op(fn, a, b, 1'($urandom_range(1, 0)));
  endtask

  // each cycle the sender idles with the given percentage
  task automatic run_phase(input int unsigned idle_pct, input int unsigned count);
    repeat (count) begin
      while ($urandom_range(99, 0) < idle_pct) idle_gap(1);
      random_op();
    end
    wait_results_done();
  endtask

  // watchdog
  initial begin
    #(2_000_000);
    $display("integer_alu_32bit regression: fail");
    $finish;
  end

  // stimulus
  initial begin
    sb           = new();
    rst_n        = 1'b0;
    start        = 1'b0;
    in_func      = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    in_predicate = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners, at least one per function plus two undefined codes
    send_op(ialu_pkg::FUNC_NOR,    32'h0000_0000, 32'h0000_0000, 1'b1);
    send_op(ialu_pkg::FUNC_AND,    32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    send_op(ialu_pkg::FUNC_OR,     32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_op(ialu_pkg::FUNC_XOR,    32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b0);
    send_op(ialu_pkg::FUNC_EQ,     32'h8000_0000, 32'h8000_0000, 1'b1);
    send_op(ialu_pkg::FUNC_NE,     32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_op(ialu_pkg::FUNC_LT,     32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_op(ialu_pkg::FUNC_LTU,    32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_op(ialu_pkg::FUNC_GTE,    32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_op(ialu_pkg::FUNC_GTEU,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    // shift amounts with the upper bits of operand_b set
    send_op(ialu_pkg::FUNC_SLL,    32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
    send_op(ialu_pkg::FUNC_SRL,    32'h8000_0000, 32'h0000_003F, 1'b0);
    send_op(ialu_pkg::FUNC_SRA,    32'h8000_0000, 32'hFFFF_FFE1, 1'b1);
    send_op(ialu_pkg::FUNC_ADD,    32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    send_op(ialu_pkg::FUNC_SUB,    32'h8000_0000, 32'h0000_0001, 1'b1);
    send_op(ialu_pkg::FUNC_PSEL,   32'hDEAD_BEEF, 32'h1234_5678, 1'b1);
    send_op(ialu_pkg::FUNC_PSEL,   32'hDEAD_BEEF, 32'h1234_5678, 1'b0);
    send_op(ialu_pkg::FUNC_MULHW,  32'h8000_0000, 32'h8000_0000, 1'b1);
    send_op(ialu_pkg::FUNC_MULLW,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_op(ialu_pkg::FUNC_MULHWU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // count of zero gives the full width
    send_op(ialu_pkg::FUNC_CLZ,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_op(ialu_pkg::FUNC_CLZ,    32'h8000_0000, 32'h0000_0000, 1'b1);
    send_op(ialu_pkg::FUNC_CLZ,    32'h0000_0001, 32'h0000_0000, 1'b0);
    send_op(FUNC_FIRST_UNDEF,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_op(FUNC_LAST_UNDEF,       32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    wait_results_done();

    // random phases: back to back, mostly idle, lightly idle
    run_phase(0, RANDOM_PER_PHASE);
    run_phase(67, RANDOM_PER_PHASE);
    run_phase(17, RANDOM_PER_PHASE);

    if (sb.fail_cnt == 0) begin
      $display("integer_alu_32bit regression: pass");
    end else begin
      $display("integer_alu_32bit regression: fail");
    end
    $finish;
  end

endmodule

// ===== integer_alu_32bit.f =====
+incdir+hw/rtl
hw/rtl/ialu_pkg.sv
hw/rtl/ialu_mul.sv
hw/rtl/ialu_clz.sv
hw/rtl/ialu_exec.sv
hw/rtl/integer_alu_32bit.sv
bench/integer_alu_32bit_tb.sv
